// ===== hdl/freq_residency_table_top_assert.svh =====
// assertion macros for the frequency residency table
`ifndef FREQ_RESIDENCY_TABLE_TOP_ASSERT_SVH
`define FREQ_RESIDENCY_TABLE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define FRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FRT_ASSERT(label, prop, msg)

`define FRT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/frt_pkg.sv =====
package frt_pkg;

    localparam int FRT_TABLE_ENTRIES = 16;

    localparam int FREQ_W  = 32;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int ACC_W   = 64;
    localparam int STAT_W  = 3;
    localparam int MS_W    = 10;
    localparam int WUS_W   = 26;
    localparam int PROD_W  = WUS_W + TIME_W;
    localparam int ENTRY_W = FREQ_W + 2 * ACC_W;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = STAT_W;

    localparam logic [MS_W-1:0] US_PER_MS = 10'd1000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_REJECT     = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_ZERO_TOTAL = 3'd3,
        STAT_EMPTY      = 3'd4
    } frt_status_t;

endpackage

// ===== hdl/frt_ram.sv =====
module frt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/freq_residency_table_top.sv =====
// channel   dir  tdata (low bit up)                           tuser       tlast
// s_axis    in   freq_hz, busy_ticks, total_ticks, window_ms  cmd         -
// m_axis    out  entry_freq, entry_run_us, entry_idle_us      status      last
// cfg       in   cfg_wdata = enable, written when cfg_we      -           -
//
// a sample runs a key search through the table ram (an address step and a compare
// step per entry), one multiply, 26 steps of the serial divider, two passes
// through the shared 64-bit saturating adder and one write. a read takes an
// address step and an emit step per entry. the table needs no clearing pass after
// reset. a stalled output word holds the block in its last step.
`include "freq_residency_table_top_assert.svh"

module freq_residency_table_top #(
    parameter int TABLE_ENTRIES = frt_pkg::FRT_TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // freq_hz, busy_ticks, total_ticks, window_ms
    input  logic [frt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [frt_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_freq, entry_run_us, entry_idle_us
    output logic [frt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [frt_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast
);

    import frt_pkg::*;

    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int DCW   = $clog2(WUS_W);
    localparam int PAD_W = ACC_W - WUS_W;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_CHECK    = 12'b0000_0000_0010,
        ST_RD_ADDR  = 12'b0000_0000_0100,
        ST_RD_EMIT  = 12'b0000_0000_1000,
        ST_SR_ADDR  = 12'b0000_0001_0000,
        ST_SR_CMP   = 12'b0000_0010_0000,
        ST_MUL      = 12'b0000_0100_0000,
        ST_DIV      = 12'b0000_1000_0000,
        ST_ADD_RUN  = 12'b0001_0000_0000,
        ST_ADD_IDLE = 12'b0010_0000_0000,
        ST_WRITE    = 12'b0100_0000_0000,
        ST_ONE      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic              enable_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic              m_valid_reg, m_valid_next;

    logic              cmd_reg, cmd_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [TIME_W-1:0] busy_reg, busy_next;
    logic [TIME_W-1:0] total_reg, total_next;
    logic [WIN_W-1:0]  win_ms_reg, win_ms_next;
    logic [WUS_W-1:0]  win_us_reg, win_us_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [FREQ_W-1:0] res_freq_reg, res_freq_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              new_reg, new_next;
    logic [ACC_W-1:0]  acc_run_reg, acc_run_next;
    logic [ACC_W-1:0]  acc_idle_reg, acc_idle_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [WUS_W-1:0]  quo_reg, quo_next;

    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [FREQ_W-1:0] out_freq_reg, out_freq_next;
    logic [ACC_W-1:0]  out_run_reg, out_run_next;
    logic [ACC_W-1:0]  out_idle_reg, out_idle_next;
    logic              out_last_reg, out_last_next;

    logic               out_free;
    logic               out_load;
    logic               rd_last;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [FREQ_W-1:0]  rd_key;
    logic [ACC_W-1:0]   rd_run;
    logic [ACC_W-1:0]   rd_idle;
    logic [PROD_W-1:0]  prod;
    logic [TIME_W+1:0]  div_diff;
    logic [ACC_W-1:0]   add_a;
    logic [ACC_W-1:0]   add_b;
    logic [ACC_W:0]     add_sum;
    logic [ACC_W-1:0]   add_sat;

    frt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[FREQ_W-1:0];
    assign rd_run  = ram_rdata[FREQ_W+ACC_W-1:FREQ_W];
    assign rd_idle = ram_rdata[ENTRY_W-1:FREQ_W+ACC_W];
    assign ram_wdata = {acc_idle_reg, acc_run_reg, freq_reg};

    assign out_free = !m_valid_reg || m_axis_tready;
    assign rd_last  = (CW'(idx_reg + 1'b1) == count_reg);

    // multiplier, divider step and shared saturating adder
    assign prod     = {{TIME_W{1'b0}}, win_us_reg} * {{WUS_W{1'b0}}, busy_reg};
    assign div_diff = {1'b0, rem_reg, quo_reg[WUS_W-1]} - {2'b00, total_reg};
    assign add_a    = (state_reg == ST_ADD_RUN) ? acc_run_reg : acc_idle_reg;
    assign add_b    = (state_reg == ST_ADD_RUN) ? {{PAD_W{1'b0}}, quo_reg}
                                                : {{PAD_W{1'b0}}, win_us_reg - quo_reg};
    assign add_sum  = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat  = add_sum[ACC_W] ? {ACC_W{1'b1}} : add_sum[ACC_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        div_cnt_next    = div_cnt_reg;
        cmd_next        = cmd_reg;
        freq_next       = freq_reg;
        busy_next       = busy_reg;
        total_next      = total_reg;
        win_ms_next     = win_ms_reg;
        win_us_next     = win_us_reg;
        res_status_next = res_status_reg;
        res_freq_next   = res_freq_reg;
        slot_next       = slot_reg;
        new_next        = new_reg;
        acc_run_next    = acc_run_reg;
        acc_idle_next   = acc_idle_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        out_status_next = out_status_reg;
        out_freq_next   = out_freq_reg;
        out_run_next    = out_run_reg;
        out_idle_next   = out_idle_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = s_axis_tuser[0];
                    freq_next   = s_axis_tdata[31:0];
                    busy_next   = s_axis_tdata[63:32];
                    total_next  = s_axis_tdata[95:64];
                    win_ms_next = s_axis_tdata[111:96];
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                win_us_next = {{MS_W{1'b0}}, win_ms_reg} * {{WIN_W{1'b0}}, US_PER_MS};
                busy_next   = (busy_reg > total_reg) ? total_reg : busy_reg;
                idx_next    = '0;
                if (cmd_reg == CMD_READ)
                begin
                    if (count_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                        res_freq_next   = '0;
                        state_next      = ST_ONE;
                    end
                    else
                    begin
                        state_next = ST_RD_ADDR;
                    end
                end
                else if (!enable_reg || freq_reg == '0)
                begin
                    res_status_next = STAT_REJECT;
                    res_freq_next   = '0;
                    state_next      = ST_ONE;
                end
                else if (total_reg == '0)
                begin
                    res_status_next = STAT_ZERO_TOTAL;
                    res_freq_next   = freq_reg;
                    state_next      = ST_ONE;
                end
                else
                begin
                    state_next = ST_SR_ADDR;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = STAT_OK;
                    out_freq_next   = rd_key;
                    out_run_next    = rd_run;
                    out_idle_next   = rd_idle;
                    out_last_next   = rd_last;
                    if (rd_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = CW'(idx_reg + 1'b1);
                        state_next = ST_RD_ADDR;
                    end
                end
            end
            ST_SR_ADDR:
            begin
                if (idx_reg == count_reg)
                begin
                    if (count_reg == CW'(TABLE_ENTRIES))
                    begin
                        res_status_next = STAT_FULL;
                        res_freq_next   = freq_reg;
                        state_next      = ST_ONE;
                    end
                    else
                    begin
                        new_next      = 1'b1;
                        slot_next     = count_reg[AW-1:0];
                        acc_run_next  = '0;
                        acc_idle_next = '0;
                        state_next    = ST_MUL;
                    end
                end
                else
                begin
                    state_next = ST_SR_CMP;
                end
            end
            ST_SR_CMP:
            begin
                if (rd_key == freq_reg)
                begin
                    new_next      = 1'b0;
                    slot_next     = idx_reg[AW-1:0];
                    acc_run_next  = rd_run;
                    acc_idle_next = rd_idle;
                    state_next    = ST_MUL;
                end
                else
                begin
                    idx_next   = CW'(idx_reg + 1'b1);
                    state_next = ST_SR_ADDR;
                end
            end
            ST_MUL:
            begin
                // product stays below total * 2^26, so the upper part starts below total
                rem_next     = prod[PROD_W-1:WUS_W];
                quo_next     = prod[WUS_W-1:0];
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_diff[TIME_W+1])
                begin
                    rem_next = div_diff[TIME_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[TIME_W-2:0], quo_reg[WUS_W-1]};
                end
                quo_next     = {quo_reg[WUS_W-2:0], !div_diff[TIME_W+1]};
                div_cnt_next = DCW'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == DCW'(WUS_W - 1))
                begin
                    state_next = ST_ADD_RUN;
                end
            end
            ST_ADD_RUN:
            begin
                acc_run_next = add_sat;
                state_next   = ST_ADD_IDLE;
            end
            ST_ADD_IDLE:
            begin
                acc_idle_next = add_sat;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    out_load        = 1'b1;
                    out_status_next = STAT_OK;
                    out_freq_next   = freq_reg;
                    out_run_next    = acc_run_reg;
                    out_idle_next   = acc_idle_reg;
                    out_last_next   = 1'b1;
                    if (new_reg)
                    begin
                        count_next = CW'(count_reg + 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = res_status_reg;
                    out_freq_next   = res_freq_reg;
                    out_run_next    = '0;
                    out_idle_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        freq_reg       <= freq_next;
        busy_reg       <= busy_next;
        total_reg      <= total_next;
        win_ms_reg     <= win_ms_next;
        win_us_reg     <= win_us_next;
        res_status_reg <= res_status_next;
        res_freq_reg   <= res_freq_next;
        slot_reg       <= slot_next;
        new_reg        <= new_next;
        acc_run_reg    <= acc_run_next;
        acc_idle_reg   <= acc_idle_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        out_status_reg <= out_status_next;
        out_freq_reg   <= out_freq_next;
        out_run_reg    <= out_run_next;
        out_idle_reg   <= out_idle_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_idle_reg, out_run_reg, out_freq_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    `FRT_ASSERT(a_count_bound, count_reg <= CW'(TABLE_ENTRIES), "entry count above table size")
    `FRT_ASSERT(a_quo_bound, (state_reg == ST_ADD_RUN) |-> (quo_reg <= win_us_reg), "run share above window")
    `FRT_ASSERT_NEXT(a_read_clears, (state_reg == ST_RD_EMIT) && out_free && rd_last, count_reg == '0, "table not cleared after read")

endmodule
